[rtl/ggls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro gesture level selector package
// Shared types, constants and lookup functions for the level selector.
// ----------------------------------------------------------------------------
package ggls_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int GAIN_BITS  = 16;
    localparam int HOLD_BITS  = 8;
    localparam int COUNT_BITS = 9;
    localparam int LEVEL_BITS = 10;
    localparam int INDEX_BITS = 3;
    localparam int SENS_BITS  = 12;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_Q8    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_LIMIT = 1'b1;
    localparam int CFG_DATA_BITS = GAIN_BITS;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;
    localparam logic [HOLD_BITS-1:0] HOLD_RESET = 8'd5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic signed [LEVEL_BITS-1:0] LEVEL_MAX = 10'sd399;
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = -10'sd399;

    // Item kinds.
    localparam logic KIND_SAMPLE   = 1'b0;
    localparam logic KIND_RECENTER = 1'b1;

    typedef enum logic [1:0] {
        MOTION_IDLE = 2'd0,
        MOTION_UP   = 2'd1,
        MOTION_DOWN = 2'd2
    } t_motion;

    // Level divided by 100 toward zero, plus 3. The level is already clamped
    // to -399..399, so a set of threshold compares covers every case.
    function automatic logic [INDEX_BITS-1:0] level_to_index(
        input logic signed [LEVEL_BITS-1:0] lvl
    );
        logic [INDEX_BITS-1:0] idx;
        if (lvl >= 10'sd300)       idx = 3'd6;
        else if (lvl >= 10'sd200)  idx = 3'd5;
        else if (lvl >= 10'sd100)  idx = 3'd4;
        else if (lvl > -10'sd100)  idx = 3'd3;
        else if (lvl > -10'sd200)  idx = 3'd2;
        else if (lvl > -10'sd300)  idx = 3'd1;
        else                       idx = 3'd0;
        return idx;
    endfunction

    // Sensitivity steps 0.005 .. 0.04 in Q0.16, rounded to nearest.
    function automatic logic [SENS_BITS-1:0] index_to_sens(
        input logic [INDEX_BITS-1:0] idx
    );
        logic [SENS_BITS-1:0] sens;
        case (idx)
            3'd0:    sens = 12'd328;
            3'd1:    sens = 12'd459;
            3'd2:    sens = 12'd590;
            3'd3:    sens = 12'd655;
            3'd4:    sens = 12'd1311;
            3'd5:    sens = 12'd1966;
            3'd6:    sens = 12'd2621;
            default: sens = 12'd2621;
        endcase
        return sens;
    endfunction

endpackage
`default_nettype wire

[rtl/gyro_gesture_level_selector.sv]
`default_nettype none
// A transaction accepted into the input register moves on to the output register
//   once that register is empty or being taken.
// Throughput: one transaction per cycle while the output is not stalled; the input
//   register and the result register form a two-stage pipeline.
// Reset (synchronous, active low): tracker idle, count and level zero,
//   gain 1.0 (Q8.8) and hold limit 5; both pipeline stages empty.
// ----------------------------------------------------------------------------
// Gyro gesture level selector
// Tracks gestures on one gyro axis, accumulates a clamped level while a
// gesture is active and maps that level onto one of seven sensitivities.
// ----------------------------------------------------------------------------
module gyro_gesture_level_selector #(
    parameter int SAMPLE_BITS = ggls_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration write port.
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [ggls_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [ggls_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // Input channel.
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_kind,
    input  wire logic signed [SAMPLE_BITS-1:0]          i_sample_now,
    input  wire logic signed [SAMPLE_BITS-1:0]          i_sample_before,
    // Output channel.
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [ggls_pkg::LEVEL_BITS-1:0]      o_level,
    output logic [ggls_pkg::INDEX_BITS-1:0]             o_level_index,
    output logic [ggls_pkg::SENS_BITS-1:0]              o_sensitivity_q16
);
    import ggls_pkg::*;

    // Configuration registers. Write them only while the block is idle; the block itself does not enforce this.
    logic [GAIN_BITS-1:0] r_gain_q8;
    logic [HOLD_BITS-1:0] r_hold_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_q8    <= GAIN_RESET;
            r_hold_limit <= HOLD_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GAIN_Q8:    r_gain_q8    <= i_cfg_data;
                CFG_HOLD_LIMIT: r_hold_limit <= HOLD_BITS'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Pipeline control. The input stage moves forward whenever the result
    // register is empty or being taken, so a new transaction is accepted
    // even while a finished result still waits at the output.
    logic out_blocked;
    logic advance;
    logic in_accept;

    logic                          r_s1_valid;
    logic                          r_s1_kind;
    logic signed [SAMPLE_BITS-1:0] r_s1_now;
    logic signed [SAMPLE_BITS-1:0] r_s1_before;

    assign out_blocked = o_out_valid && i_out_stall;
    assign advance     = r_s1_valid && !out_blocked;
    assign o_in_stall  = r_s1_valid && out_blocked;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind   <= i_kind;
            r_s1_now    <= i_sample_now;
            r_s1_before <= i_sample_before;
        end
    end

    // The level, and for samples the tracker, update as the registered
    // transaction moves into the result register, so the next transaction
    // sees the new state.
    logic                         is_sample;
    logic                         active;
    logic signed [LEVEL_BITS-1:0] level_next;
    logic [INDEX_BITS-1:0]        index_next;

    assign is_sample = r_s1_kind == KIND_SAMPLE;

    ggls_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_update        (advance && is_sample),
        .i_sample_now    (r_s1_now),
        .i_sample_before (r_s1_before),
        .i_hold_limit    (r_hold_limit),
        .o_active        (active)
    );

    ggls_level #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_level (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (advance),
        .i_recenter   (r_s1_kind == KIND_RECENTER),
        .i_active     (active),
        .i_sample_now (r_s1_now),
        .i_gain_q8    (r_gain_q8),
        .o_level_next (level_next)
    );

    assign index_next = level_to_index(level_next);

    // Result register.
    logic                         r_out_valid;
    logic signed [LEVEL_BITS-1:0] r_out_level;
    logic [INDEX_BITS-1:0]        r_out_index;
    logic [SENS_BITS-1:0]         r_out_sens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_level <= level_next;
            r_out_index <= index_next;
            r_out_sens  <= index_to_sens(index_next);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_level           = r_out_level;
    assign o_level_index     = r_out_index;
    assign o_sensitivity_q16 = r_out_sens;

endmodule
`default_nettype wire

[rtl/ggls_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Gesture tracker
// Three-state motion tracker with reversal counting and hold limit.
// ----------------------------------------------------------------------------
module ggls_tracker #(
    parameter int SAMPLE_BITS = ggls_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_update,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample_now,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample_before,
    input  wire logic [ggls_pkg::HOLD_BITS-1:0]     i_hold_limit,
    output logic                                    o_active
);
    import ggls_pkg::*;

    t_motion               r_state;
    t_motion               n_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    t_motion               start_state;
    logic                  reversal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MOTION_IDLE;
            r_count <= '0;
        end else if (i_update) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        // A zero sample or an unknown code drops back to idle first.
        if (i_sample_now == '0 || (r_state != MOTION_UP && r_state != MOTION_DOWN)) begin
            start_state = MOTION_IDLE;
        end else begin
            start_state = r_state;
        end

        n_state  = start_state;
        n_count  = r_count;
        reversal = 1'b0;
        case (start_state)
            MOTION_UP: begin
                reversal = i_sample_now > i_sample_before;
            end
            MOTION_DOWN: begin
                reversal = i_sample_now < i_sample_before;
            end
            default: begin
                if (i_sample_now < 0 && i_sample_now <= i_sample_before) begin
                    n_state = MOTION_UP;
                end else if (i_sample_now > 0 && i_sample_now >= i_sample_before) begin
                    n_state = MOTION_DOWN;
                end
                n_count = '0;
            end
        endcase

        if (start_state == MOTION_UP || start_state == MOTION_DOWN) begin
            if (!reversal) begin
                n_count = '0;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end

        if (n_count > COUNT_BITS'(i_hold_limit)) begin
            n_state = MOTION_IDLE;
        end

        o_active = n_state != MOTION_IDLE;
    end

endmodule
`default_nettype wire

[rtl/ggls_level.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Level accumulator
// Scales a sample by the Q8.8 gain and adds it to the clamped level.
// ----------------------------------------------------------------------------
module ggls_level #(
    parameter int SAMPLE_BITS = ggls_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_update,
    input  wire logic                                   i_recenter,
    input  wire logic                                   i_active,
    input  wire logic signed [SAMPLE_BITS-1:0]          i_sample_now,
    input  wire logic [ggls_pkg::GAIN_BITS-1:0]         i_gain_q8,
    output logic signed [ggls_pkg::LEVEL_BITS-1:0]      o_level_next
);
    import ggls_pkg::*;

    localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int DW = PW - 8;
    localparam int SW = LEVEL_BITS + 2;

    logic signed [LEVEL_BITS-1:0] r_level;
    logic signed [LEVEL_BITS-1:0] n_level;
    logic signed [PW-1:0]         sample_ext;
    logic signed [PW-1:0]         gain_ext;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         prod_adj;
    logic signed [DW-1:0]         delta;
    logic signed [SW-1:0]         delta_sat;
    logic signed [SW-1:0]         sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_update) begin
            r_level <= n_level;
        end
    end

    always_comb begin
        sample_ext = PW'(i_sample_now);
        gain_ext   = signed'(PW'(i_gain_q8));
        prod       = sample_ext * gain_ext;
        // Divide by 256 truncating toward zero.
        prod_adj   = prod + (prod < 0 ? PW'(255) : PW'(0));
        delta      = DW'(prod_adj >>> 8);

        // Anything above 1023 or below -1024 clamps the level anyway.
        if (delta > DW'(1023)) begin
            delta_sat = SW'(1023);
        end else if (delta < -DW'(1024)) begin
            delta_sat = -SW'(1024);
        end else begin
            delta_sat = SW'(delta);
        end

        sum = SW'(r_level) + delta_sat;

        if (i_recenter) begin
            n_level = '0;
        end else if (!i_active) begin
            n_level = r_level;
        end else if (sum > SW'(LEVEL_MAX)) begin
            n_level = LEVEL_MAX;
        end else if (sum < SW'(LEVEL_MIN)) begin
            n_level = LEVEL_MIN;
        end else begin
            n_level = LEVEL_BITS'(sum);
        end

        o_level_next = n_level;
    end

endmodule
`default_nettype wire

[tb/gyro_gesture_level_selector_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro gesture level selector testbench
// Drives directed and random gyro samples and recenter commands through the
// selector under several gain and hold settings. A local copy of the gesture
// tracker predicts the level, index and sensitivity of each transaction, and
// every result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module gyro_gesture_level_selector_test;
    import ggls_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 80;

    // One input transaction and one predicted result.
    typedef struct {
        logic                    kind;
        logic signed [15:0]      sample_now;
        logic signed [15:0]      sample_prev;
    } t_gyro_item;

    typedef struct {
        logic signed [LEVEL_BITS-1:0] level;
        logic [INDEX_BITS-1:0]        index;
        logic [SENS_BITS-1:0]         sens;
    } t_level_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_GAIN_Q8;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_kind = KIND_SAMPLE;
    logic signed [15:0] i_sample_now = '0;
    logic signed [15:0] i_sample_before = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [LEVEL_BITS-1:0] o_level;
    logic [INDEX_BITS-1:0] o_level_index;
    logic [SENS_BITS-1:0] o_sensitivity_q16;

    // Stimulus waiting for the driver, and results predicted but not yet seen.
    t_gyro_item pending_items[$];
    t_level_result level_expected[$];
    int outstanding = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Idle percentages for each side, changed from phase to phase.
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    bit hold_off_request = 1'b0;
    int hold_off_left = 0;
    bit in_fire = 1'b0;

    // Local copy of the tracker state and the two registers.
    t_motion model_motion = MOTION_IDLE;
    logic [COUNT_BITS-1:0] model_count = '0;
    logic signed [LEVEL_BITS-1:0] model_level = '0;
    logic [GAIN_BITS-1:0] model_gain = GAIN_RESET;
    logic [HOLD_BITS-1:0] model_hold = HOLD_RESET;

    // State of the random gesture generator: a walk that moves in one
    // direction and turns around now and then.
    int walk = 0;
    int walk_dir = 1;

    t_level_result want;

    gyro_gesture_level_selector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_sample_now     (i_sample_now),
        .i_sample_before  (i_sample_before),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_level          (o_level),
        .o_level_index    (o_level_index),
        .o_sensitivity_q16(o_sensitivity_q16)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advances the local tracker by one transaction and returns the result
    // the block should produce for it.
    function automatic t_level_result track_gesture(input t_gyro_item it);
        t_level_result r;
        longint c;
        longint p;
        longint prod;
        longint sum;
        int idx;
        c = it.sample_now;
        p = it.sample_prev;
        if (it.kind == KIND_RECENTER) begin
            // Recenter only clears the level; the tracker keeps its state.
            model_level = '0;
        end else begin
            if (c == 0)
                model_motion = MOTION_IDLE;
            if (model_motion == MOTION_IDLE) begin
                // A gesture starts only when the sample is not easing back
                // toward zero.
                if (c < 0 && c <= p)
                    model_motion = MOTION_UP;
                else if (c > 0 && c >= p)
                    model_motion = MOTION_DOWN;
                model_count = '0;
            end else if ((model_motion == MOTION_UP) ? (c > p) : (c < p)) begin
                if (model_count != COUNT_MAX)
                    model_count = model_count + 1'b1;
            end else begin
                model_count = '0;
            end
            if (model_count > model_hold)
                model_motion = MOTION_IDLE;
            if (model_motion != MOTION_IDLE) begin
                // Integer division truncates toward zero, as the gain
                // scaling requires for negative products.
                prod = c * longint'(model_gain);
                sum = longint'(model_level) + prod / 256;
                if (sum > LEVEL_MAX)
                    sum = LEVEL_MAX;
                if (sum < LEVEL_MIN)
                    sum = LEVEL_MIN;
                model_level = sum[LEVEL_BITS-1:0];
            end
        end
        idx = int'(model_level) / 100 + 3;
        r.level = model_level;
        r.index = idx[INDEX_BITS-1:0];
        case (idx)
            0:       r.sens = 12'd328;
            1:       r.sens = 12'd459;
            2:       r.sens = 12'd590;
            3:       r.sens = 12'd655;
            4:       r.sens = 12'd1311;
            5:       r.sens = 12'd1966;
            default: r.sens = 12'd2621;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic push_item(input logic kind, input int now_val, input int prev_val);
        t_gyro_item it;
        it.kind = kind;
        it.sample_now = now_val[15:0];
        it.sample_prev = prev_val[15:0];
        pending_items.push_back(it);
        outstanding = outstanding + 1;
    endtask

    // Register writes happen only while nothing is in flight, so the local
    // copy can take the new value at the same time.
    task automatic write_setting(input logic [CFG_INDEX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        if (idx == CFG_GAIN_Q8)
            model_gain = data;
        else
            model_hold = data[HOLD_BITS-1:0];
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        i_cfg_data = CFG_DATA_BITS'($urandom);
    endtask

    task automatic configure(input logic [15:0] gain, input logic [15:0] hold_word,
                             input int send_pct, input int recv_pct);
        write_setting(CFG_GAIN_Q8, gain);
        write_setting(CFG_HOLD_LIMIT, hold_word);
        sender_idle_pct = send_pct;
        receiver_idle_pct = recv_pct;
    endtask

    // Waits until every queued transaction has produced its result, then
    // lets the two pipeline stages run empty.
    task automatic settle();
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Most items continue a gesture-like walk, so the tracker spends time in
    // the up and down states and sees reversal runs of varying length. The
    // rest are recenters, zero samples and unrelated noise.
    task automatic queue_random_gestures(input int count);
        int roll;
        int stride;
        int now_val;
        int prev_val;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            prev_val = walk;
            if (roll < 5) begin
                push_item(KIND_RECENTER, $urandom, $urandom);
            end else if (roll < 11) begin
                walk = 0;
                push_item(KIND_SAMPLE, 0, prev_val);
            end else if (roll < 20) begin
                now_val = $signed(16'($urandom));
                walk = now_val;
                push_item(KIND_SAMPLE, now_val, $urandom);
            end else begin
                if ($urandom_range(0, 3) == 0)
                    walk_dir = -walk_dir;
                stride = $urandom_range(0, 60);
                if ($urandom_range(0, 19) == 0)
                    stride = $urandom_range(1, 20000);
                now_val = walk + walk_dir * stride;
                if (now_val > 32767)
                    now_val = 32767;
                if (now_val < -32768)
                    now_val = -32768;
                walk = now_val;
                push_item(KIND_SAMPLE, now_val, prev_val);
            end
        end
    endtask

    // Driver: a new transaction is offered only once the current one has
    // been taken, so a stalled payload stays put.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                t_gyro_item it;
                it = pending_items.pop_front();
                i_in_valid <= 1'b1;
                i_kind <= it.kind;
                i_sample_now <= it.sample_now;
                i_sample_before <= it.sample_prev;
            end else begin
                i_in_valid <= 1'b0;
                i_kind <= 1'($urandom);
                i_sample_now <= 16'($urandom);
                i_sample_before <= 16'($urandom);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that fills the
    // pipeline and forces the block to stall its input.
    always @(negedge i_clk) begin
        if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0) begin
            hold_off_left = hold_off_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Monitor: checks each result against the oldest prediction, then
    // predicts the transaction taken at this edge. A result can never belong
    // to a transaction taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_expected.size() == 0) begin
                report_mismatch("result with no transaction waiting for it");
            end else begin
                want = level_expected.pop_front();
                outstanding = outstanding - 1;
                if (o_level !== want.level)
                    report_mismatch($sformatf("level %0d, expected %0d",
                                              o_level, want.level));
                if (o_level_index !== want.index)
                    report_mismatch($sformatf("level index %0d, expected %0d",
                                              o_level_index, want.index));
                if (o_sensitivity_q16 !== want.sens)
                    report_mismatch($sformatf("sensitivity %0d, expected %0d",
                                              o_sensitivity_q16, want.sens));
            end
        end
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire)
            level_expected.push_back(track_gesture('{i_kind, i_sample_now, i_sample_before}));
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at unity gain and the default hold limit. The sender
        // idles often and the receiver stalls more often still.
        configure(16'd256, 16'd5, 34, 70);
        push_item(KIND_RECENTER, 0, 0);         // recenter straight out of reset
        push_item(KIND_SAMPLE, 0, 0);           // zero sample keeps the tracker idle
        push_item(KIND_SAMPLE, -1, 0);          // smallest negative sample starts up
        push_item(KIND_SAMPLE, -32768, -1);     // most negative sample clamps low
        // Six reversals in a row push the count past the hold limit.
        push_item(KIND_SAMPLE, -100, -32768);
        push_item(KIND_SAMPLE, -80, -100);
        push_item(KIND_SAMPLE, -60, -80);
        push_item(KIND_SAMPLE, -40, -60);
        push_item(KIND_SAMPLE, -20, -40);
        push_item(KIND_SAMPLE, -10, -20);
        push_item(KIND_RECENTER, -1, 32767);
        push_item(KIND_SAMPLE, 32767, 32767);   // equal samples still start down
        push_item(KIND_SAMPLE, 32767, -32768);  // clamps high
        push_item(KIND_SAMPLE, 50, 60);         // one reversal in down
        push_item(KIND_SAMPLE, 0, 50);          // zero sample forces idle
        push_item(KIND_SAMPLE, 5, 10);          // easing toward zero: no gesture
        push_item(KIND_SAMPLE, -5, -10);
        push_item(KIND_RECENTER, 0, 0);
        // Walk the level across the index boundaries.
        push_item(KIND_SAMPLE, 99, 99);
        push_item(KIND_SAMPLE, 1, 1);
        push_item(KIND_SAMPLE, 100, 100);
        push_item(KIND_SAMPLE, 99, 99);
        push_item(KIND_SAMPLE, 1, 1);
        settle();

        // Largest gain with a zero hold limit; upper bits of the hold word
        // must be ignored.
        configure(16'hFFFF, 16'hFF00, 34, 70);
        queue_random_gestures(200);
        settle();

        // Now the roles swap: the receiver stalls less than the sender idles.
        configure(16'h0000, 16'hA5FF, 70, 34);
        queue_random_gestures(150);
        settle();

        configure(16'($urandom), {8'($urandom), 8'($urandom_range(0, 8))}, 70, 34);
        queue_random_gestures(200);
        settle();

        // Full rate on both sides, with one long hold-off at the receiver.
        configure(16'h0010, 16'h0002, 0, 0);
        queue_random_gestures(150);
        hold_off_request = 1'b1;
        settle();

        configure(16'h0001, 16'h00FF, 0, 0);
        queue_random_gestures(130);
        settle();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/ggls_pkg.sv
rtl/ggls_tracker.sv
rtl/ggls_level.sv
rtl/gyro_gesture_level_selector.sv
tb/gyro_gesture_level_selector_test.sv
